[design/alarm_clock_button_controller_macros.svh]
// assertion macros of the alarm clock button controller rtl
// expects clk and rst_n in the scope of the module that uses them
`ifndef ALARM_CLOCK_BUTTON_CONTROLLER_MACROS_SVH
`define ALARM_CLOCK_BUTTON_CONTROLLER_MACROS_SVH

// same-cycle implication, off during reset
`define ACBC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("acbc same-cycle check failed");

// next-cycle implication, off during reset
`define ACBC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("acbc next-cycle check failed");

`endif

[design/acbc_pkg.sv]
// types and constants of the alarm clock button controller
// no dependencies; used by every rtl file of the block
package acbc_pkg;

    localparam logic [5:0] MAX_MINUTE       = 6'd59;
    localparam logic [4:0] MAX_HOUR         = 5'd23;
    localparam logic [3:0] LONG_PRESS_RESET = 4'd10;

    localparam logic [1:0] BTN_MODE = 2'd0;
    localparam logic [1:0] BTN_MIN  = 2'd1;
    localparam logic [1:0] BTN_HOUR = 2'd2;

    localparam logic [1:0] ARM_CMD_ON  = 2'd1;
    localparam logic [1:0] ARM_CMD_OFF = 2'd2;

    typedef struct packed {
        logic       sample_strobe;
        logic       repeat_strobe;
        logic       check_strobe;
        logic       mode_button_n;
        logic       minute_button_n;
        logic       hour_button_n;
        logic [4:0] time_hour;
        logic [5:0] time_minute;
        logic       remote_time_valid;
        logic [7:0] remote_hour;
        logic [7:0] remote_minute;
        logic [1:0] remote_arm;
    } in_word_t;

    typedef struct packed {
        logic [4:0] alarm_hour_out;
        logic [5:0] alarm_minute_out;
        logic [4:0] shown_hour;
        logic [5:0] shown_minute;
        logic       in_set_mode;
        logic       armed;
        logic       ringing;
        logic       buzzer_on;
        logic       colon_on;
        logic       persist_request;
        logic       mode_beep;
    } out_word_t;

endpackage

[design/acbc_in_reg.sv]
// input register of the alarm clock button controller
// depends on acbc_pkg for the input word type
module acbc_in_reg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  acbc_pkg::in_word_t in_data,
    input  logic              advance,
    output logic              item_valid,
    output acbc_pkg::in_word_t item
);

    logic               vld_reg;
    logic               vld_next;
    acbc_pkg::in_word_t word_reg;
    logic               accept;

    // a held word that moves on this cycle frees the register for the next
    assign in_stall = vld_reg && !advance;
    assign accept   = in_valid && !in_stall;
    assign vld_next = accept || (vld_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= in_data;
        end
    end

    assign item_valid = vld_reg;
    assign item       = word_reg;

endmodule

[design/acbc_core.sv]
// button, alarm and buzzer state of the alarm clock button controller
// plus the result register; depends on acbc_pkg and the macros header
`include "alarm_clock_button_controller_macros.svh"

module acbc_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  acbc_pkg::in_word_t  item,
    output logic                advance,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [3:0]          cfg_data,
    output logic                out_valid,
    input  logic                out_stall,
    output acbc_pkg::out_word_t out_data
);

    logic [3:0]      long_press_reg;
    logic [2:0]      last_reg,  last_next;
    logic [2:0][3:0] hold_reg,  hold_next;
    logic            set_mode_reg, set_mode_next;
    logic [4:0]      ahour_reg, ahour_next;
    logic [5:0]      amin_reg,  amin_next;
    logic [4:0]      phour_reg, phour_next;
    logic [5:0]      pmin_reg,  pmin_next;
    logic            arm_reg,   arm_next;
    logic            ring_reg,  ring_next;
    logic            blink_reg, blink_next;
    logic            bphase_reg, bphase_next;
    logic            blevel_reg, blevel_next;
    logic            out_valid_reg, out_valid_next;
    acbc_pkg::out_word_t result_reg, result_next;

    logic [3:0] lim;
    logic [2:0] lv;
    logic [2:0] ev;
    logic       beep;
    logic       persist;
    logic       min_step;
    logic       hour_step;
    logic [4:0] rem_hour;
    logic [5:0] rem_min;

    assign advance   = item_valid && (!out_valid_reg || !out_stall);
    assign cfg_ready = !item_valid && !out_valid_reg;
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    always_comb
    begin
        lim = (long_press_reg == 4'd0) ? 4'd1 : long_press_reg;
        lv  = {item.hour_button_n, item.minute_button_n, item.mode_button_n};
        ev        = '0;
        beep      = 1'b0;
        persist   = 1'b0;
        min_step  = 1'b0;
        hour_step = 1'b0;
        last_next     = last_reg;
        hold_next     = hold_reg;
        set_mode_next = set_mode_reg;
        ahour_next    = ahour_reg;
        amin_next     = amin_reg;
        phour_next    = phour_reg;
        pmin_next     = pmin_reg;
        arm_next      = arm_reg;
        ring_next     = ring_reg;
        blink_next    = blink_reg;
        bphase_next   = bphase_reg;
        blevel_next   = blevel_reg;

        case (item.remote_arm)
            acbc_pkg::ARM_CMD_ON:  arm_next = 1'b1;
            acbc_pkg::ARM_CMD_OFF: arm_next = 1'b0;
            default:               arm_next = arm_reg;
        endcase

        // edge detect and saturating hold count per button
        if (item.sample_strobe)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (lv[i])
                begin
                    hold_next[i] = 4'd0;
                end
                else if (last_reg[i])
                begin
                    ev[i]        = 1'b1;
                    hold_next[i] = 4'd0;
                end
                else if (hold_reg[i] < lim)
                begin
                    hold_next[i] = hold_reg[i] + 4'd1;
                end
                else
                begin
                    hold_next[i] = lim;
                end
            end
            if (hold_next[acbc_pkg::BTN_MODE] >= lim)
            begin
                set_mode_next = !set_mode_reg;
                hold_next     = '0;
                ev[acbc_pkg::BTN_MIN]  = 1'b0;
                ev[acbc_pkg::BTN_HOUR] = 1'b0;
                beep = 1'b1;
            end
            last_next = lv;
        end

        // a press steps once; a long hold steps on each repeat strobe
        if (set_mode_next)
        begin
            min_step  = (hold_next[acbc_pkg::BTN_MIN] >= lim) ? item.repeat_strobe
                                                              : ev[acbc_pkg::BTN_MIN];
            hour_step = (hold_next[acbc_pkg::BTN_HOUR] >= lim) ? item.repeat_strobe
                                                               : ev[acbc_pkg::BTN_HOUR];
        end
        if (min_step)
        begin
            amin_next = (amin_reg >= acbc_pkg::MAX_MINUTE) ? 6'd0 : amin_reg + 6'd1;
        end
        if (hour_step)
        begin
            ahour_next = (ahour_reg >= acbc_pkg::MAX_HOUR) ? 5'd0 : ahour_reg + 5'd1;
        end

        if (set_mode_reg && !set_mode_next
            && (phour_reg != ahour_next || pmin_reg != amin_next))
        begin
            phour_next = ahour_next;
            pmin_next  = amin_next;
            persist    = 1'b1;
        end

        if (!set_mode_next && hold_next[acbc_pkg::BTN_MIN] >= lim
            && hold_next[acbc_pkg::BTN_HOUR] >= lim)
        begin
            arm_next = !arm_next;
            hold_next[acbc_pkg::BTN_MIN]  = 4'd0;
            hold_next[acbc_pkg::BTN_HOUR] = 4'd0;
        end

        rem_hour = (item.remote_hour > {3'd0, acbc_pkg::MAX_HOUR}) ? 5'd0
                                                                 : item.remote_hour[4:0];
        rem_min  = (item.remote_minute > {2'd0, acbc_pkg::MAX_MINUTE}) ? 6'd0
                                                                     : item.remote_minute[5:0];
        if (item.remote_time_valid && (rem_hour != ahour_next || rem_min != amin_next))
        begin
            ahour_next = rem_hour;
            amin_next  = rem_min;
            phour_next = rem_hour;
            pmin_next  = rem_min;
            persist    = 1'b1;
        end

        if (item.check_strobe)
        begin
            blink_next = !blink_reg;
            ring_next  = arm_next && item.time_hour == ahour_next
                         && item.time_minute == amin_next;
            if (ring_next && bphase_reg)
            begin
                blevel_next = 1'b1;
                bphase_next = 1'b0;
            end
            else
            begin
                blevel_next = 1'b0;
                bphase_next = 1'b1;
            end
        end

        result_next.alarm_hour_out   = ahour_next;
        result_next.alarm_minute_out = amin_next;
        result_next.shown_hour       = set_mode_next ? ahour_next : item.time_hour;
        result_next.shown_minute     = set_mode_next ? amin_next : item.time_minute;
        result_next.in_set_mode      = set_mode_next;
        result_next.armed            = arm_next;
        result_next.ringing          = ring_next;
        result_next.buzzer_on        = blevel_next;
        result_next.colon_on         = set_mode_next || blink_next;
        result_next.persist_request  = persist;
        result_next.mode_beep        = beep;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg <= acbc_pkg::LONG_PRESS_RESET;
            last_reg       <= '1;
            hold_reg       <= '0;
            set_mode_reg   <= 1'b0;
            ahour_reg      <= '0;
            amin_reg       <= '0;
            phour_reg      <= '0;
            pmin_reg       <= '0;
            arm_reg        <= 1'b0;
            ring_reg       <= 1'b0;
            blink_reg      <= 1'b1;
            bphase_reg     <= 1'b0;
            blevel_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                long_press_reg <= cfg_data;
            end
            if (advance)
            begin
                last_reg     <= last_next;
                hold_reg     <= hold_next;
                set_mode_reg <= set_mode_next;
                ahour_reg    <= ahour_next;
                amin_reg     <= amin_next;
                phour_reg    <= phour_next;
                pmin_reg     <= pmin_next;
                arm_reg      <= arm_next;
                ring_reg     <= ring_next;
                blink_reg    <= blink_next;
                bphase_reg   <= bphase_next;
                blevel_reg   <= blevel_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = result_reg;

    `ACBC_ASSERT_NOW(a_alarm_in_range, 1'b1, ahour_reg <= acbc_pkg::MAX_HOUR && amin_reg <= acbc_pkg::MAX_MINUTE)
    `ACBC_ASSERT_NEXT(a_beep_on_toggle, advance, (set_mode_reg != $past(set_mode_reg)) == result_reg.mode_beep)
    `ACBC_ASSERT_NOW(a_persist_matches, out_valid_reg && result_reg.persist_request, phour_reg == ahour_reg && pmin_reg == amin_reg)
    `ACBC_ASSERT_NOW(a_buzz_needs_ring, out_valid_reg && result_reg.buzzer_on, result_reg.ringing)

endmodule

[design/alarm_clock_button_controller.sv]
// top level of the alarm clock button controller
// depends on acbc_pkg, acbc_in_reg and acbc_core
//
// Takes one tick word per clock cycle unless the output stalls, and returns one result
// word per tick: the tick is captured in an input register at the edge that accepts it,
// all button, alarm and buzzer updates are done in one pass of logic from that register
// and the state registers, and the result lands in an output register when the core
// advances. A stalled output holds its word while the input register still takes one
// more tick. The long press threshold is written through the cfg port, which is ready
// only while no tick or result is held; a value of 0 acts as 1.
module alarm_clock_button_controller
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  acbc_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output acbc_pkg::out_word_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [3:0]          cfg_data
);

    logic               item_valid;
    acbc_pkg::in_word_t item;
    logic               advance;

    acbc_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    acbc_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule
